// ===== rtl/ertm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertm_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ertm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 16;
    localparam int ITERS          = 30;
    localparam int NLANE          = 3;
    localparam int XY_W           = 33;
    localparam int Z_W            = 32;
    localparam int CS_W           = 32;
    localparam int R_W            = 34;
    localparam int P_W            = 64;
    localparam int NENT           = 9;

    localparam logic signed [XY_W-1:0] GAIN    = 33'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30 = 33'sd1073741824;

    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             q;
    } t_lane;

    typedef t_lane [NLANE-1:0] t_lanes;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turn(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667332;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // binary angle -> quadrant and residual in [-1/8, 1/8) turn
    function automatic t_lane lane_init(input logic [IN_W-1:0] a, input int ab);
        logic [31:0] a32;
        logic [31:0] r;
        t_lane       l;
        a32  = (32'(a) & ((32'd1 << ab) - 32'd1)) << (32 - ab);
        r    = a32 + 32'h2000_0000;
        l.q  = r[31:30];
        l.z  = $signed({2'b00, r[29:0]}) - 32'sh2000_0000;
        l.x  = GAIN;
        l.y  = '0;
        return l;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/euler_to_rotation_matrix.sv =====
// Pipeline from input request to result: 1 angle stage, 30 CORDIC
// cells, 6 matrix stages, the last being the output register.
// Throughput: one request per cycle; the whole pipeline holds while the
// result is not taken.
// Reset clears only the valid flags; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Yaw, pitch and roll binary angles to a 3x3 rotation matrix in fixed point.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS = ertm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ertm_pkg::FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [47:0]  i_s_tdata,   // yaw_angle, pitch_angle, roll_angle
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [143:0] o_m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
    import ertm_pkg::*;

    logic   w_en;
    t_lanes n_lanes0;
    t_lanes r_lanes0;
    logic   r_v0;

    t_lanes w_lanes [ITERS+1];
    logic   w_v     [ITERS+1];

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            n_lanes0[k] = lane_init(i_s_tdata[k*IN_W +: IN_W], ANGLE_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lanes0 <= n_lanes0;
        end
    end

    assign w_lanes[0] = r_lanes0;
    assign w_v[0]     = r_v0;

    for (genvar g = 0; g < ITERS; g++) begin : g_cell
        ertm_cordic_cell #(
            .ITER (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_lanes (w_lanes[g]),
            .o_valid (w_v[g+1]),
            .o_lanes (w_lanes[g+1])
        );
    end

    ertm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v[ITERS]),
        .i_lanes (w_lanes[ITERS]),
        .o_valid (o_m_tvalid),
        .o_m     (o_m_tdata)
    );

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");
    a_out_cleared: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
    a_entry_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_v0)
        else $error("accepted request not captured");
`endif

endmodule
`default_nettype wire

// ===== rtl/ertm_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertm_cordic_cell
// One rotation-mode CORDIC iteration for the yaw, pitch and roll lanes.
// ----------------------------------------------------------------------------
module ertm_cordic_cell #(
    parameter int ITER = 0
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_en,
    input  wire            i_valid,
    input  wire  ertm_pkg::t_lanes i_lanes,
    output logic           o_valid,
    output ertm_pkg::t_lanes o_lanes
);
    import ertm_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(ITER);

    t_lanes n_lanes;
    t_lanes r_lanes;
    logic   r_valid;

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            n_lanes[k].q = i_lanes[k].q;
            if (!i_lanes[k].z[Z_W-1]) begin
                n_lanes[k].x = i_lanes[k].x - (i_lanes[k].y >>> ITER);
                n_lanes[k].y = i_lanes[k].y + (i_lanes[k].x >>> ITER);
                n_lanes[k].z = i_lanes[k].z - ATAN;
            end else begin
                n_lanes[k].x = i_lanes[k].x + (i_lanes[k].y >>> ITER);
                n_lanes[k].y = i_lanes[k].y - (i_lanes[k].x >>> ITER);
                n_lanes[k].z = i_lanes[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule
`default_nettype wire

// ===== rtl/ertm_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ertm_matrix
// Quadrant fix-up, products, sums, rounding and saturation of the 3x3 matrix.
// ----------------------------------------------------------------------------
module ertm_matrix #(
    parameter int FRAC_BITS = ertm_pkg::FRAC_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire  ertm_pkg::t_lanes i_lanes,
    output logic             o_valid,
    output logic [ertm_pkg::NENT*ertm_pkg::OUT_W-1:0] o_m
);
    import ertm_pkg::*;

    localparam int NP = 10;

    function automatic logic signed [CS_W-1:0] clamp(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = v;
        if (v > ONE_Q30) t = ONE_Q30;
        if (v < -ONE_Q30) t = -ONE_Q30;
        return CS_W'(t);
    endfunction

    function automatic logic [OUT_W-1:0] finish(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] s;
        logic signed [P_W-1:0] lim;
        lim = P_W'(64'sd1 <<< FRAC_BITS);
        s   = (v + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s[OUT_W-1:0];
    endfunction

    logic [5:0] r_v;

    logic signed [CS_W-1:0] r_c [NLANE];
    logic signed [CS_W-1:0] r_s [NLANE];

    logic signed [P_W-1:0]  r_p2 [NP];
    logic signed [CS_W-1:0] r_sb2, r_cb2, r_sp2;

    logic signed [R_W-1:0]  r_hs3, r_hc3;
    logic signed [P_W-1:0]  r_p3 [NP];
    logic signed [CS_W-1:0] r_sb3, r_cb3, r_sp3;

    logic signed [P_W-1:0]  r_t4 [4];
    logic signed [P_W-1:0]  r_p4 [NP];
    logic signed [CS_W-1:0] r_sp4;

    logic signed [P_W-1:0]  r_e [NENT];
    logic [OUT_W-1:0]       r_m [NENT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NLANE; k++) begin
                case (i_lanes[k].q)
                    2'd0: begin
                        r_c[k] <= clamp(i_lanes[k].x);
                        r_s[k] <= clamp(i_lanes[k].y);
                    end
                    2'd1: begin
                        r_c[k] <= -clamp(i_lanes[k].y);
                        r_s[k] <= clamp(i_lanes[k].x);
                    end
                    2'd2: begin
                        r_c[k] <= -clamp(i_lanes[k].x);
                        r_s[k] <= -clamp(i_lanes[k].y);
                    end
                    default: begin
                        r_c[k] <= clamp(i_lanes[k].y);
                        r_s[k] <= -clamp(i_lanes[k].x);
                    end
                endcase
            end

            // stage 2: two-factor products, Q60
            r_p2[0] <= r_s[LANE_YAW] * r_s[LANE_PITCH];
            r_p2[1] <= r_c[LANE_YAW] * r_s[LANE_PITCH];
            r_p2[2] <= r_c[LANE_YAW] * r_c[LANE_ROLL];
            r_p2[3] <= r_s[LANE_ROLL] * r_c[LANE_PITCH];
            r_p2[4] <= r_s[LANE_YAW] * r_c[LANE_ROLL];
            r_p2[5] <= r_c[LANE_YAW] * r_s[LANE_ROLL];
            r_p2[6] <= r_c[LANE_ROLL] * r_c[LANE_PITCH];
            r_p2[7] <= r_s[LANE_ROLL] * r_s[LANE_YAW];
            r_p2[8] <= r_s[LANE_YAW] * r_c[LANE_PITCH];
            r_p2[9] <= r_c[LANE_YAW] * r_c[LANE_PITCH];
            r_sb2   <= r_s[LANE_ROLL];
            r_cb2   <= r_c[LANE_ROLL];
            r_sp2   <= r_s[LANE_PITCH];

            // stage 3: round the first pair of three-factor terms to Q30
            r_hs3 <= R_W'((r_p2[0] + 64'sd536870912) >>> 30);
            r_hc3 <= R_W'((r_p2[1] + 64'sd536870912) >>> 30);
            r_p3  <= r_p2;
            r_sb3 <= r_sb2;
            r_cb3 <= r_cb2;
            r_sp3 <= r_sp2;

            // stage 4: third factor
            r_t4[0] <= r_hs3 * r_sb3;
            r_t4[1] <= r_hc3 * r_sb3;
            r_t4[2] <= r_hs3 * r_cb3;
            r_t4[3] <= r_hc3 * r_cb3;
            r_p4    <= r_p3;
            r_sp4   <= r_sp3;

            // stage 5: sums
            r_e[0] <= r_p4[2] + r_t4[0];
            r_e[1] <= r_p4[3];
            r_e[2] <= r_t4[1] - r_p4[4];
            r_e[3] <= r_t4[2] - r_p4[5];
            r_e[4] <= r_p4[6];
            r_e[5] <= r_p4[7] + r_t4[3];
            r_e[6] <= r_p4[8];
            r_e[7] <= -(P_W'(r_sp4) <<< 30);
            r_e[8] <= r_p4[9];

            // stage 6: round and saturate
            for (int k = 0; k < NENT; k++) begin
                r_m[k] <= finish(r_e[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NENT; k++) begin
            o_m[k*OUT_W +: OUT_W] = r_m[k];
        end
    end

    assign o_valid = r_v[5];

`ifndef ASSERT_OFF
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("valid pipe moved while stalled");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("valid pipe not cleared by reset");
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid |=> r_v[0])
        else $error("request lost entering matrix stages");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the Euler-angle to rotation-matrix pipeline: a directed table of
// angle triples followed by random triples, with random gaps on both stream
// sides, each result compared per entry to a stored or behavioral CORDIC matrix.
// ----------------------------------------------------------------------------
module tb_top;
    import ertm_pkg::*;

    localparam int AB        = ANGLE_BITS_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RAND    = 400;
    localparam int WDOG_MAX  = 5000;
    localparam int LATENCY   = 37;
    localparam logic [15:0] P1 = 16'(1 << FB);
    localparam logic [15:0] M1 = 16'(-(1 << FB));

    typedef logic [143:0] t_mat;

    typedef struct {
        logic [47:0] req;
        bit          known;
        t_mat        mat;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [47:0]  i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    wire          o_s_tready;
    wire          o_m_tvalid;
    wire  [143:0] o_m_tdata;

    t_mat   mat_queue[$];
    int     n_err = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     idle_cycles = 0;
    bit     sending_done = 1'b0;

    euler_to_rotation_matrix dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // yaw, pitch, roll
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)     // m00, m01, m02, m10, m11, m12, m20, m21, m22
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sra(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp1(longint v);
        if (v > (longint'(1) << 30)) return longint'(1) << 30;
        if (v < -(longint'(1) << 30)) return -(longint'(1) << 30);
        return v;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        logic [31:0] a32;
        logic [31:0] r;
        longint x, y, z, nx;
        a32 = (32'(ang) & ((32'd1 << AB) - 1)) << (32 - AB);
        r = a32 + 32'h2000_0000;
        z = longint'(r[29:0]) - 64'h2000_0000;
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
                nx = x - sra(y, i);
                y = y + sra(x, i);
                z -= longint'(atan_turn(i));
            end else begin
                nx = x + sra(y, i);
                y = y - sra(x, i);
                z += longint'(atan_turn(i));
            end
            x = nx;
        end
        x = clamp1(x);
        y = clamp1(y);
        case (r[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint prod3(longint a, longint b, longint c);
        return sra(a * b + (longint'(1) << 29), 30) * c;
    endfunction

    function automatic logic [15:0] to_q(longint q60);
        longint v;
        longint lim;
        lim = longint'(1) << FB;
        v = sra(q60 + (longint'(1) << (59 - FB)), 60 - FB);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    function automatic t_mat rotation(logic [47:0] req);
        longint ch, sh, cp, sp, cb, sb;
        t_mat m;
        sin_cos(req[15:0], ch, sh);
        sin_cos(req[31:16], cp, sp);
        sin_cos(req[47:32], cb, sb);
        m[15:0]    = to_q(ch * cb + prod3(sh, sp, sb));
        m[31:16]   = to_q(sb * cp);
        m[47:32]   = to_q(-sh * cb + prod3(ch, sp, sb));
        m[63:48]   = to_q(-ch * sb + prod3(sh, sp, cb));
        m[79:64]   = to_q(cb * cp);
        m[95:80]   = to_q(sb * sh + prod3(ch, sp, cb));
        m[111:96]  = to_q(sh * cp);
        m[127:112] = to_q(-sp * (longint'(1) << 30));
        m[143:128] = to_q(ch * cp);
        return m;
    endfunction

    task automatic report(string what, int idx, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s entry %0d: got %0d expected %0d at %0t",
                 what, idx, $signed(got), $signed(want), $realtime);
        n_err++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic send(logic [47:0] req, bit known, t_mat mat);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= req;
        mat_queue.push_back(known ? mat : rotation(req));
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    // sink side: random backpressure, compare against oldest expectation
    always @(posedge i_clk) begin
        t_mat want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_got++;
                if (mat_queue.size() == 0) begin
                    $display("unexpected matrix at %0t", $realtime);
                    n_err++;
                end else begin
                    want = mat_queue.pop_front();
                    for (int e = 0; e < NENT; e++)
                        if (o_m_tdata[e*16 +: 16] !== want[e*16 +: 16])
                            report("matrix", e, o_m_tdata[e*16 +: 16], want[e*16 +: 16]);
                end
            end
            i_m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("watchdog expired, %0d pending", mat_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    t_row table_rows[14] = '{
        '{48'h0000_0000_0000, 1'b1, {P1, 16'd0, 16'd0, 16'd0, P1, 16'd0, 16'd0, 16'd0, P1}},
        '{48'h0000_4000_0000, 1'b1, {16'd0, M1, 16'd0, P1, 16'd0, 16'd0, 16'd0, 16'd0, P1}},
        '{48'h0000_C000_0000, 1'b0, '0},
        '{48'h0000_0000_4000, 1'b0, '0},
        '{48'h4000_0000_0000, 1'b0, '0},
        '{48'h8000_8000_8000, 1'b0, '0},
        '{48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{48'h0001_0001_0001, 1'b0, '0},
        '{48'h2000_2000_2000, 1'b0, '0},
        '{48'hE000_6000_A000, 1'b0, '0},
        '{48'h1FFF_2000_DFFF, 1'b0, '0},
        '{48'h5555_AAAA_5555, 1'b0, '0},
        '{48'h7FFF_8001_3FFF, 1'b0, '0},
        '{48'hC000_4000_8000, 1'b0, '0}
    };

    initial begin
        logic [47:0] req;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[k])
            send(table_rows[k].req, table_rows[k].known, table_rows[k].mat);
        i_s_tvalid <= 1'b0;
        // drain before random traffic
        while (mat_queue.size() != 0) @(posedge i_clk);
        for (int n = 0; n < N_RAND; n++) begin
            req = 48'({$urandom, $urandom});
            if ($urandom_range(0, 4) == 0)
                req[15:0] = 16'($urandom_range(0, 3)) << 14 ^ 16'($urandom_range(0, 2));
            send(req, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;
        sending_done = 1'b1;
        while (mat_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);
        $display("sent %0d angle triples, checked %0d matrices", n_sent, n_got);
        if (n_err == 0 && mat_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
